>>> hdl/adc_scan_averager_core_defines.svh
// Assertion macros for the ADC scan averager.
// Used by the core; depends on nothing else.
`ifndef ADC_SCAN_AVERAGER_CORE_DEFINES_SVH
`define ADC_SCAN_AVERAGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ASA_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ASA_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ASA_CHECK(label, clk, rst_n, prop, msg)
`define ASA_CHECK_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/asa_pkg.sv
// Shared types and constants of the ADC scan averager.
// No dependencies; used by the interfaces, the core and the testbench.
`default_nettype none

package asa_pkg;

    localparam int LOG2_SAMPLES_DEF = 4;
    localparam int SLOTS_DEF        = 8;
    localparam int MAX_SLOTS        = 8;

    localparam int SAMPLE_W      = 10;
    localparam int SLOT_W        = 3;
    localparam int MUX_W         = 5;
    localparam int MUX_TABLE_W   = MAX_SLOTS * MUX_W;
    localparam int CHAN_CNT_W    = 4;
    localparam int ACC_W         = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = MUX_TABLE_W;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MUX_TABLE     = 2'd1;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [SLOT_W-1:0]   read_index;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] read_value;
        logic [MUX_W-1:0]    mux_code;
        logic                average_done;
        logic [SLOT_W-1:0]   done_slot;
    } t_out_item;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

endpackage

`default_nettype wire

>>> hdl/asa_in_if.sv
// Input request channel of the ADC scan averager.
// Depends on asa_pkg for the payload type.
`default_nettype none

interface asa_in_if import asa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/asa_out_if.sv
// Result channel of the ADC scan averager.
// Depends on asa_pkg for the payload type.
`default_nettype none

interface asa_out_if import asa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/asa_cfg_if.sv
// Configuration write channel of the ADC scan averager.
// Depends on asa_pkg for the request type.
`default_nettype none

interface asa_cfg_if import asa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/adc_scan_averager_core.sv
// ADC scan averager core: accumulator, slot pointer, averages store, result register.
// Depends on asa_pkg, the three channel interfaces and the assertion header.
`default_nettype none

`include "adc_scan_averager_core_defines.svh"

// Round-robin scan averager. Each sample request adds a conversion result to the
// accumulator until 2^LOG2_SAMPLES samples are held; the following sample is
// dropped as settling and instead stores the average for the current slot and
// advances the slot pointer, which wraps after channel_count-1. A read request
// returns a stored average. Every request gives one result, registered in the cycle
// after acceptance; a new request is taken every cycle, the single accumulate and
// compare stage setting that rate, and a result that waits downstream holds off
// the input until it is taken. The averages store resets to zero at once,
// with no clearing pass. Write configuration only while no request is in flight.
module adc_scan_averager_core import asa_pkg::*; #(
    parameter int LOG2_SAMPLES = LOG2_SAMPLES_DEF,
    parameter int SLOTS        = SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    asa_cfg_if.sink     i_cfg,
    asa_in_if.sink      i_in,
    asa_out_if.source   o_out
);

    localparam int CNT_W = LOG2_SAMPLES + 1;
    localparam logic [CNT_W-1:0]      BLOCK_LEN = CNT_W'(2 ** LOG2_SAMPLES);
    localparam logic [CHAN_CNT_W-1:0] SLOT_CNT  = CHAN_CNT_W'(SLOTS);

    logic [CHAN_CNT_W-1:0]  r_chan_count;
    logic [MUX_TABLE_W-1:0] r_mux_table;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [SAMPLE_W-1:0]    r_avg [SLOTS];
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic                   in_fire;
    logic                   avg_we;
    logic [CHAN_CNT_W-1:0]  eff_count;
    logic [CHAN_CNT_W-1:0]  slot_inc;
    logic [SAMPLE_W-1:0]    avg_value;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // clamp the rotation length into 1..SLOTS
    always_comb begin
        if (r_chan_count == '0) begin
            eff_count = CHAN_CNT_W'(1);
        end else if (r_chan_count > SLOT_CNT) begin
            eff_count = SLOT_CNT;
        end else begin
            eff_count = r_chan_count;
        end
    end

    assign slot_inc  = {1'b0, r_slot} + CHAN_CNT_W'(1);
    assign avg_value = SAMPLE_W'(r_acc >> LOG2_SAMPLES);

    always_comb begin
        n_count = r_count;
        n_acc   = r_acc;
        n_slot  = r_slot;
        avg_we  = 1'b0;
        n_out   = r_out;
        if (in_fire) begin
            n_out.read_value   = '0;
            n_out.average_done = 1'b0;
            n_out.done_slot    = '0;
            if (i_in.data.op == OP_READ) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (i_in.data.read_index == SLOT_W'(i)) begin
                        n_out.read_value = r_avg[i];
                    end
                end
            end else if (r_count < BLOCK_LEN) begin
                n_count = r_count + CNT_W'(1);
                n_acc   = r_acc + ACC_W'(i_in.data.sample);
            end else begin
                // settling sample: store the average, drop the sample, advance
                avg_we             = 1'b1;
                n_out.average_done = 1'b1;
                n_out.done_slot    = r_slot;
                n_count            = '0;
                n_acc              = '0;
                n_slot = (slot_inc >= eff_count) ? '0 : slot_inc[SLOT_W-1:0];
            end
            n_out.mux_code = r_mux_table[n_slot * MUX_W +: MUX_W];
        end
    end

    always_comb begin
        if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= CHAN_CNT_W'(1);
            r_mux_table  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.addr)
                CFG_CHANNEL_COUNT: r_chan_count <= i_cfg.data.data[CHAN_CNT_W-1:0];
                CFG_MUX_TABLE:     r_mux_table  <= i_cfg.data.data[MUX_TABLE_W-1:0];
                default: begin
                    // ignore writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acc       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_avg[i] <= '0;
            end
        end else if (avg_we) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_slot == SLOT_W'(i)) begin
                    r_avg[i] <= avg_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `ASA_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= BLOCK_LEN, "sample count past block length")
    `ASA_CHECK(a_slot_bound, i_clk, i_rst_n, {1'b0, r_slot} < SLOT_CNT, "slot pointer out of range")
    `ASA_CHECK_NEXT(a_block_clear, i_clk, i_rst_n, in_fire && i_in.data.op == OP_SAMPLE && r_count == BLOCK_LEN, r_count == '0 && r_acc == '0 && r_out_valid && r_out.average_done, "block end did not clear the accumulator")
    `ASA_CHECK_NEXT(a_read_keeps_state, i_clk, i_rst_n, in_fire && i_in.data.op == OP_READ, $stable(r_slot) && $stable(r_count) && $stable(r_acc) && !r_out.average_done, "read request changed scan state")

endmodule

`default_nettype wire

>>> dv/tb_adc_scan_averager_core.sv
// Self-checking testbench for adc_scan_averager_core: random sender and receiver
// idling, a request-level scan predictor and in-order result checking.
// Depends on asa_pkg, the three channel interfaces and the core.
`default_nettype none

module tb_adc_scan_averager_core;
    import asa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_SHIFT    = LOG2_SAMPLES_DEF;
    localparam int NUM_SLOTS    = SLOTS_DEF;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 89;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 100;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    logic i_clk;
    logic i_rst_n;

    asa_cfg_if cfg_if ();
    asa_in_if  in_if ();
    asa_out_if out_if ();

    adc_scan_averager_core #(
        .LOG2_SAMPLES (AVG_SHIFT),
        .SLOTS        (NUM_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Scan state mirrored by the predictor
    logic [CHAN_CNT_W-1:0]  scan_count;
    logic [MUX_TABLE_W-1:0] scan_mux_table;
    logic [4:0]             held_samples;
    logic [ACC_W-1:0]       sample_sum;
    logic [SLOT_W-1:0]      scan_slot;
    logic [SAMPLE_W-1:0]    slot_averages [NUM_SLOTS];

    t_in_item  scan_requests [$];
    t_out_item predicted_out [$];

    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned stall_draw;
    logic        send_burst;
    logic        recv_burst;

    int n_requests;
    int n_reads;
    int n_averages;
    int n_cfg_writes;
    int n_errors;
    int n_cycles;

    int fixed_counts [6] = '{8, 0, 15, 9, 1, 5};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_scan(t_in_item req);
        t_out_item res;
        int        span;
        int        next_slot;
        res = '0;
        if (req.op == OP_READ) begin
            if (req.read_index < NUM_SLOTS) res.read_value = slot_averages[req.read_index];
        end else if (held_samples < (1 << AVG_SHIFT)) begin
            held_samples = held_samples + 1'b1;
            sample_sum   = sample_sum + req.sample;
        end else begin
            // settling sample: drop it, store the average and advance the slot
            slot_averages[scan_slot] = SAMPLE_W'(sample_sum >> AVG_SHIFT);
            res.average_done = 1'b1;
            res.done_slot    = scan_slot;
            sample_sum       = '0;
            held_samples     = '0;
            span = scan_count;
            if (span == 0) span = 1;
            if (span > NUM_SLOTS) span = NUM_SLOTS;
            next_slot = int'(scan_slot) + 1;
            if (next_slot >= span) next_slot = 0;
            scan_slot = SLOT_W'(next_slot);
        end
        res.mux_code = scan_mux_table[scan_slot * MUX_W +: MUX_W];
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        req.op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_SAMPLE;
        case ($urandom_range(0, 7))
            0:       req.sample = '0;
            1:       req.sample = '1;
            default: req.sample = SAMPLE_W'($urandom);
        endcase
        req.read_index = SLOT_W'($urandom);
        return req;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{addr: idx, data: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_CHANNEL_COUNT: scan_count     = val[CHAN_CNT_W-1:0];
            CFG_MUX_TABLE:     scan_mux_table = val[MUX_TABLE_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every request is taken and every result is back; sample
    // between edges so the driver's updates have settled.
    task automatic wait_idle();
        while (scan_requests.size() != 0 || in_if.valid || predicted_out.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predicted_out.push_back(predict_scan(in_if.data));
                n_requests++;
                if (in_if.data.op == OP_READ) n_reads++;
                if (predicted_out[$].average_done) n_averages++;
            end
            if (in_if.valid && !in_if.ready) begin
                // hold the request until taken
            end else if (send_gap != 0) begin
                in_if.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (scan_requests.size() != 0) begin
                in_if.data  <= scan_requests.pop_front();
                in_if.valid <= 1'b1;
                send_gap    <= send_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 47) == 0) send_burst <= !send_burst;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall   <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (predicted_out.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got %p",
                                 $time, out_if.data);
                end else if (out_if.data.read_value   !== predicted_out[0].read_value   ||
                             out_if.data.mux_code     !== predicted_out[0].mux_code     ||
                             out_if.data.average_done !== predicted_out[0].average_done ||
                             out_if.data.done_slot    !== predicted_out[0].done_slot) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $display("%0t: result mismatch, expected %p, got %p",
                                 $time, predicted_out[0], out_if.data);
                end
                if (predicted_out.size() != 0) void'(predicted_out.pop_front());
                stall_draw = recv_burst ? 0 : $urandom_range(0, 15);
                recv_stall   <= stall_draw;
                out_if.ready <= (stall_draw == 0);
                if ($urandom_range(0, 47) == 0) recv_burst <= !recv_burst;
            end else if (recv_stall > 1) begin
                recv_stall   <= recv_stall - 1;
                out_if.ready <= 1'b0;
            end else begin
                recv_stall   <= 0;
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("[adc_scan_averager_core] ERROR");
            $finish;
        end
    end

    initial begin
        int                    phase;
        int                    k;
        logic [CHAN_CNT_W-1:0] count_sel;
        logic [63:0]           wide;
        logic [CFG_DATA_W-1:0] tbl_val;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        n_requests   = 0;
        n_reads      = 0;
        n_averages   = 0;
        n_cfg_writes = 0;
        n_errors     = 0;
        n_cycles     = 0;

        scan_count     = 4'd1;
        scan_mux_table = '0;
        held_samples   = '0;
        sample_sum     = '0;
        scan_slot      = '0;
        foreach (slot_averages[i]) slot_averages[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Spare indexes must leave both registers at their reset values
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);

        // Directed: reset averages, full-scale block, settling zero, readback
        scan_requests.push_back('{op: OP_READ, sample: '0, read_index: 3'd0});
        scan_requests.push_back('{op: OP_READ, sample: '1, read_index: 3'd7});
        repeat (16) scan_requests.push_back('{op: OP_SAMPLE, sample: '1, read_index: 3'd7});
        scan_requests.push_back('{op: OP_SAMPLE, sample: '0, read_index: 3'd0});
        scan_requests.push_back('{op: OP_READ, sample: '0, read_index: 3'd0});
        scan_requests.push_back('{op: OP_READ, sample: '0, read_index: 3'd7});
        wait_idle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 6) begin
                count_sel = CHAN_CNT_W'(fixed_counts[phase]);
            end else if (scan_slot != 0 && $urandom_range(0, 2) == 0) begin
                // shrink the rotation to the pointer so the next advance wraps
                count_sel = CHAN_CNT_W'(scan_slot);
            end else if ($urandom_range(0, 7) == 0) begin
                count_sel = CHAN_CNT_W'($urandom);
            end else begin
                count_sel = CHAN_CNT_W'($urandom_range(1, NUM_SLOTS));
            end
            write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(count_sel));

            wide = {$urandom, $urandom};
            if (phase == 0 || phase % 5 == 4) tbl_val = '1;
            else if (phase == 1)              tbl_val = '0;
            else                              tbl_val = wide[CFG_DATA_W-1:0];
            if (phase % 4 != 3) write_reg(CFG_MUX_TABLE, tbl_val);
            if (phase == 2 || phase == 7) write_reg(CFG_SPARE_A, tbl_val);
            if (phase == 9) write_reg(CFG_SPARE_B, ~tbl_val);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                scan_requests.push_back(random_request());
                // hold off mid-phase until the block has drained
                if (phase == 5 && k == PHASE_ITEMS / 2) wait_idle();
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests (%0d reads, %0d averages stored) with %0d register writes.",
                 n_requests, n_reads, n_averages, n_cfg_writes);
        $display("Channel counts 0..15 incl. rotation shrink below the pointer, %0d failures.",
                 n_errors);
        if (n_errors == 0) begin
            $display("[adc_scan_averager_core] OK");
        end else begin
            $display("[adc_scan_averager_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/asa_pkg.sv
hdl/asa_in_if.sv
hdl/asa_out_if.sv
hdl/asa_cfg_if.sv
hdl/adc_scan_averager_core.sv
dv/tb_adc_scan_averager_core.sv
